// ===== design/ttps_pkg.sv =====
// Shared types and constants for the transposition table probe/store unit.
// No dependencies; imported by every module of the block.
package ttps_pkg;

  localparam int unsigned TT_ENTRIES = 1024;
  localparam int unsigned IDX_W      = $clog2(TT_ENTRIES);

  localparam logic [1:0] REQ_STORE = 2'd0;
  localparam logic [1:0] REQ_PROBE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_ALPHA = 2'd1;
  localparam logic [1:0] KIND_BETA  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // One table slot as stored in the memory word.
  typedef struct packed {
    logic               valid;
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [5:0]         depth;
    logic [1:0]         kind;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic eval;        // resolve the pending probe into the output register
    logic sweep_step;  // clear one slot, advance the sweep counter
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;    // output register empty or draining this cycle
    logic sweep_last;  // sweep counter at the last slot
  } status_t;

endpackage

// ===== design/transposition_table_probe_store_unit.sv =====
// Transposition table, direct-mapped, always-replace: top level.
// Result: store, clear and unknown requests load the output register at the transfer;
//   a probe registers the memory read, then loads the compared result into that register.
// Input: open after a store if the output is free; shut while a probe is evaluated and
//   while a clear sweeps all TT_ENTRIES slots, one per cycle, on the single write port.
// Reset: synchronous; the same clearing sweep runs after reset before input opens.
module transposition_table_probe_store_unit import ttps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [63:0]        position_key,
  input  logic signed [15:0] score_value,
  input  logic [5:0]         search_depth,
  input  logic [1:0]         bound_kind,
  input  logic signed [15:0] lower_bound,
  input  logic signed [15:0] upper_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [15:0] result_score
);

  // Commands flow down from the controller, status flows back up.
  cmd_t    cmd;
  status_t status;

  // Controller: sequences the sweep, input transfers and probe evaluation.
  // Input opens only when the output register is free, so one result
  // register is enough for every request type.
  ttps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: the slot memory carries its own valid bit in each word,
  // so a clear is a sweep that writes every word to zero. A store writes at
  // the transfer edge; a probe in the next cycle reads the updated word,
  // so no forwarding path is needed.
  ttps_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (req_type),
    .position_key (position_key),
    .score_value  (score_value),
    .search_depth (search_depth),
    .bound_kind   (bound_kind),
    .lower_bound  (lower_bound),
    .upper_bound  (upper_bound),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .result_score (result_score)
  );

endmodule

// ===== design/ttps_ctrl.sv =====
// Controller state machine for the transposition table unit.
// Depends on ttps_pkg; drives ttps_datapath through cmd_t.
module ttps_ctrl import ttps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  status_t    status,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.eval        = 1'b0;
    cmd.sweep_step  = 1'b0;
    case (state)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = status.out_free;
        cmd.accept = in_valid && status.out_free;
        if (cmd.accept) begin
          case (req_type)
            REQ_PROBE: state_next = S_EVAL;
            REQ_CLEAR: state_next = S_SWEEP;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase
  end

endmodule

// ===== design/ttps_datapath.sv =====
// Datapath: slot memory, request registers, hit logic, output register, sweep counter.
// Depends on ttps_pkg; commanded by ttps_ctrl.
module ttps_datapath import ttps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [1:0]         req_type,
  input  logic [63:0]        position_key,
  input  logic signed [15:0] score_value,
  input  logic [5:0]         search_depth,
  input  logic [1:0]         bound_kind,
  input  logic signed [15:0] lower_bound,
  input  logic signed [15:0] upper_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [15:0] result_score
);

  entry_t mem [TT_ENTRIES];
  entry_t rdata;

  idx_t               sweep_cnt;
  idx_t               in_idx;
  logic [63:0]        key_q;
  logic [5:0]         depth_q;
  logic signed [15:0] lower_q;
  logic signed [15:0] upper_q;

  logic               probe_hit;
  logic signed [15:0] probe_score;
  logic               slot_match;

  assign in_idx = position_key[IDX_W-1:0];

  assign status.out_free   = !out_valid || out_ready;
  assign status.sweep_last = (sweep_cnt == idx_t'(TT_ENTRIES - 1));

  // Single write port: the sweep owns it while running.
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[sweep_cnt] <= '0;
    end else if (cmd.accept && req_type == REQ_STORE) begin
      mem[in_idx] <= '{valid: 1'b1, key: position_key, score: score_value,
                       depth: search_depth, kind: bound_kind};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && req_type == REQ_PROBE) begin
      rdata <= mem[in_idx];
    end
  end

  // Hold the probe operands for the evaluate cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_q   <= position_key;
      depth_q <= search_depth;
      lower_q <= lower_bound;
      upper_q <= upper_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_step) begin
      sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + idx_t'(1);
    end
  end

  assign slot_match = rdata.valid && (rdata.key == key_q) && (rdata.depth >= depth_q);

  always_comb begin
    probe_hit   = 1'b0;
    probe_score = '0;
    if (slot_match) begin
      case (rdata.kind)
        KIND_EXACT: begin
          probe_hit   = 1'b1;
          probe_score = rdata.score;
        end
        KIND_ALPHA: begin
          if (rdata.score <= lower_q) begin
            probe_hit   = 1'b1;
            probe_score = lower_q;
          end
        end
        KIND_BETA: begin
          if (rdata.score >= upper_q) begin
            probe_hit   = 1'b1;
            probe_score = upper_q;
          end
        end
        default: begin
          probe_hit = 1'b0;
        end
      endcase
    end
  end

  // Output register: non-probe results load at the input transfer,
  // probe results in the evaluate cycle that follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.eval || (cmd.accept && req_type != REQ_PROBE)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit          <= probe_hit;
      result_score <= probe_score;
    end else if (cmd.accept && req_type != REQ_PROBE) begin
      hit          <= 1'b0;
      result_score <= '0;
    end
  end

endmodule

// ===== design/ttps_checker.sv =====
// Port-level checker for the transposition table unit, with its bind statement.
// Depends on ttps_pkg and the top-level transposition_table_probe_store_unit.
module ttps_checker import ttps_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic               hit,
  input logic signed [15:0] result_score
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(result_score))
    else $error("result changed while stalled");

  // A miss always reports a zero score.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> result_score == 16'sd0)
    else $error("miss with nonzero score");

  // A store answers in the next cycle with a miss.
  a_store_resp: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_STORE |=> out_valid && !hit)
    else $error("store result missing or wrong");

  // A probe or a clear closes the input for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_PROBE || req_type == REQ_CLEAR) |=> !in_ready)
    else $error("input open while probe or sweep in progress");

endmodule

bind transposition_table_probe_store_unit ttps_checker u_ttps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .req_type     (req_type),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .hit          (hit),
  .result_score (result_score)
);
